[hw/rtl/isgs_pkg.sv]
// Shared types and constants of the innermost span gap sweep.
package isgs_pkg;

   // Field widths of the request and response words
   localparam int unsigned POS_W = 32;
   localparam int unsigned ELEMENT_ID_W = 16;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EVAL   = 4'b0010,
      ST_POP    = 4'b0100,
      ST_FINISH = 4'b1000
   } seq_state_type;

   // One response word
   typedef struct packed {
      logic [POS_W-1:0] span_begin;
      logic [POS_W-1:0] span_end;
      logic             no_span;
      logic             final_result;
      logic             stack_overflow;
   } rsp_word_type;

endpackage

[hw/rtl/isgs_req_if.sv]
// Request channel: one span edge event per word.
interface isgs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [isgs_pkg::POS_W-1:0]            edge_position;
   logic [isgs_pkg::ELEMENT_ID_W-1:0]     element_id;
   logic                                  opens;
   logic                                  represented;
   logic                                  last_event;

   modport source (
      output valid, edge_position, element_id, opens, represented, last_event,
      input  ready
   );
   modport sink (
      input  valid, edge_position, element_id, opens, represented, last_event,
      output ready
   );
endinterface

[hw/rtl/isgs_rsp_if.sv]
// Response channel: one unrepresented span or end marker per word.
interface isgs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [isgs_pkg::POS_W-1:0] span_begin;
   logic [isgs_pkg::POS_W-1:0] span_end;
   logic                       no_span;
   logic                       final_result;
   logic                       stack_overflow;

   modport source (
      output valid, span_begin, span_end, no_span, final_result, stack_overflow,
      input  ready
   );
   modport sink (
      input  valid, span_begin, span_end, no_span, final_result, stack_overflow,
      output ready
   );
endinterface

[hw/rtl/innermost_span_gap_sweep_core.sv]
// Innermost span gap sweep: element stack, pending span merge and response queue.
//
// The core takes sorted span edge words and keeps a stack of open elements in a
// single-port-write, registered-read memory of STACK_DEPTH entries. Each request
// word is taken in the idle state and evaluated in the evaluation state that follows,
// where the gap since the previous edge is charged to the innermost open element and
// either merged into the pending span or emits it; that state holds while an emitted
// span has no queue slot. An opening edge pushes in the evaluation state, or sets
// the overflow flag on a full stack. A closing edge then pops one stack entry per
// cycle until it meets its element or the stack runs empty. A word flagged
// last_event adds a finish state to flush the pending span (or an end marker) and
// clear the list state. Responses go through a two-word queue, so a stalled
// response side holds the sequencer only when the queue is full. There is no
// clearing pass after reset; the stack contents are only read below the fill count.
module innermost_span_gap_sweep_core #(
   parameter int unsigned STACK_DEPTH = 64,
   parameter int unsigned ID_WIDTH    = 16
) (
   input logic        clock,
   input logic        reset,
   isgs_req_if.sink   req_ch,
   isgs_rsp_if.source rsp_ch
);

   localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int unsigned POS_W  = isgs_pkg::POS_W;
   localparam int unsigned ENT_W  = ID_WIDTH + 1;

   // Sequencer and list state
   isgs_pkg::seq_state_type state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [POS_W-1:0]        last_pos_ff, last_pos_in;
   logic [POS_W-1:0]        pend_begin_ff, pend_begin_in;
   logic [POS_W-1:0]        pend_end_ff, pend_end_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic                    ovf_ff, ovf_in;

   // Latched request word
   logic [POS_W-1:0]    pos_ff;
   logic [ID_WIDTH-1:0] id_ff;
   logic                opens_ff;
   logic                rep_ff;
   logic                last_ff;

   // Stack memory, entry is {represented, id}
   logic [ENT_W-1:0]  stack_mem [STACK_DEPTH];
   logic [ENT_W-1:0]  rd_q;
   logic [ADDR_W-1:0] rd_addr;
   logic [CNT_W-1:0]  rd_addr_full;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ENT_W-1:0]  wr_data;

   // Response queue
   isgs_pkg::rsp_word_type q_ff [2];
   logic                   q_head_ff;
   logic [1:0]             q_cnt_ff;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_full;
   logic                   q_tail;
   isgs_pkg::rsp_word_type q_word;

   // Evaluation terms
   logic req_fire;
   logic top_rep;
   logic gap_hit;
   logic extend;
   logic emit_need;
   logic pop_match;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == isgs_pkg::ST_IDLE);

   assign top_rep   = rd_q[ID_WIDTH];
   assign gap_hit   = (count_ff != '0) && (pos_ff > last_pos_ff) && !top_rep;
   assign extend    = pend_valid_ff && (pend_end_ff == last_pos_ff);
   assign emit_need = gap_hit && pend_valid_ff && !extend;
   assign pop_match = (rd_q[ID_WIDTH-1:0] == id_ff);
   assign q_full    = (q_cnt_ff == 2'd2);
   assign q_pop     = rsp_ch.valid && rsp_ch.ready;
   assign q_tail    = q_head_ff ^ q_cnt_ff[0];

   // Read the entry under the next fill count
   assign rd_addr_full = count_in - CNT_W'(1);
   assign rd_addr      = rd_addr_full[ADDR_W-1:0];

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      last_pos_in   = last_pos_ff;
      pend_begin_in = pend_begin_ff;
      pend_end_in   = pend_end_ff;
      pend_valid_in = pend_valid_ff;
      ovf_in        = ovf_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[ADDR_W-1:0];
      wr_data       = {rep_ff, id_ff};
      q_push        = 1'b0;
      q_word        = '{span_begin: pend_begin_ff, span_end: pend_end_ff,
                        no_span: 1'b0, final_result: 1'b0, stack_overflow: 1'b0};
      unique case (state_ff)
         isgs_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = isgs_pkg::ST_EVAL;
            end
         end
         isgs_pkg::ST_EVAL: begin
            // hold while an emitted span has no queue slot
            if (!(emit_need && q_full)) begin
               if (gap_hit) begin
                  if (extend) begin
                     pend_end_in = pos_ff;
                  end else begin
                     q_push        = pend_valid_ff;
                     pend_begin_in = last_pos_ff;
                     pend_end_in   = pos_ff;
                     pend_valid_in = 1'b1;
                  end
               end
               last_pos_in = pos_ff;
               if (opens_ff) begin
                  // push, or drop and flag on a full stack
                  if (count_ff < CNT_W'(STACK_DEPTH)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  state_in = last_ff ? isgs_pkg::ST_FINISH : isgs_pkg::ST_IDLE;
               end else if (count_ff != '0) begin
                  state_in = isgs_pkg::ST_POP;
               end else begin
                  state_in = last_ff ? isgs_pkg::ST_FINISH : isgs_pkg::ST_IDLE;
               end
            end
         end
         isgs_pkg::ST_POP: begin
            // drop the top entry, stop at the matching element or empty stack
            count_in = count_ff - CNT_W'(1);
            if (pop_match || (count_ff == CNT_W'(1))) begin
               state_in = last_ff ? isgs_pkg::ST_FINISH : isgs_pkg::ST_IDLE;
            end
         end
         isgs_pkg::ST_FINISH: begin
            // flush pending span or end marker, then clear the list
            if (!q_full) begin
               q_push = 1'b1;
               q_word = '{span_begin:     pend_valid_ff ? pend_begin_ff : '0,
                          span_end:       pend_valid_ff ? pend_end_ff : '0,
                          no_span:        !pend_valid_ff,
                          final_result:   1'b1,
                          stack_overflow: ovf_ff};
               count_in      = '0;
               last_pos_in   = '0;
               pend_begin_in = '0;
               pend_end_in   = '0;
               pend_valid_in = 1'b0;
               ovf_in        = 1'b0;
               state_in      = isgs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = isgs_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and list registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= isgs_pkg::ST_IDLE;
         count_ff      <= '0;
         last_pos_ff   <= '0;
         pend_begin_ff <= '0;
         pend_end_ff   <= '0;
         pend_valid_ff <= 1'b0;
         ovf_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         last_pos_ff   <= last_pos_in;
         pend_begin_ff <= pend_begin_in;
         pend_end_ff   <= pend_end_in;
         pend_valid_ff <= pend_valid_in;
         ovf_ff        <= ovf_in;
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pos_ff   <= req_ch.edge_position;
         id_ff    <= ID_WIDTH'(req_ch.element_id);
         opens_ff <= req_ch.opens;
         rep_ff   <= req_ch.represented;
         last_ff  <= req_ch.last_event;
      end
   end

   // Stack memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_q <= stack_mem[rd_addr];
   end

   // Response queue
   always_ff @(posedge clock) begin
      if (reset) begin
         q_head_ff <= 1'b0;
         q_cnt_ff  <= '0;
      end else begin
         if (q_pop) begin
            q_head_ff <= ~q_head_ff;
         end
         q_cnt_ff <= q_cnt_ff + 2'(q_push) - 2'(q_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[q_tail] <= q_word;
      end
   end

   assign rsp_ch.valid          = (q_cnt_ff != '0);
   assign rsp_ch.span_begin     = q_ff[q_head_ff].span_begin;
   assign rsp_ch.span_end       = q_ff[q_head_ff].span_end;
   assign rsp_ch.no_span        = q_ff[q_head_ff].no_span;
   assign rsp_ch.final_result   = q_ff[q_head_ff].final_result;
   assign rsp_ch.stack_overflow = q_ff[q_head_ff].stack_overflow;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack fill count beyond depth");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= 2'd2)
      else $error("response queue count beyond two");

   a_pend_order: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_begin_ff < pend_end_ff))
      else $error("pending span is empty or reversed");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == isgs_pkg::ST_FINISH && !q_full) |=>
         (count_ff == '0 && !pend_valid_ff && !ovf_ff))
      else $error("list state not cleared after flush");

endmodule

[sim/testbench.sv]
// Self-checking testbench of the innermost span gap sweep core.

// One span edge word as offered on the request channel
typedef struct packed {
   logic [isgs_pkg::POS_W-1:0]        edge_position;
   logic [isgs_pkg::ELEMENT_ID_W-1:0] element_id;
   logic                              opens;
   logic                              represented;
   logic                              last_event;
} span_event_type;

// Tracks the open-element stack and the pending span, queues the expected words
class span_sweep_scoreboard;
   localparam int unsigned DEPTH = 64;

   logic [isgs_pkg::ELEMENT_ID_W-1:0] open_ids [DEPTH];
   bit                                open_rep [DEPTH];
   int unsigned                       depth;
   logic [isgs_pkg::POS_W-1:0]        last_pos;
   logic [isgs_pkg::POS_W-1:0]        pend_begin;
   logic [isgs_pkg::POS_W-1:0]        pend_end;
   bit                                pend_valid;
   bit                                ovf_seen;
   isgs_pkg::rsp_word_type            expected_words [$];
   int unsigned                       failures;

   function new();
      failures = 0;
      clear_list();
   endfunction

   function void clear_list();
      depth      = 0;
      last_pos   = '0;
      pend_begin = '0;
      pend_end   = '0;
      pend_valid = 1'b0;
      ovf_seen   = 1'b0;
   endfunction

   function void note_event(span_event_type ev);
      isgs_pkg::rsp_word_type word;
      // charge the gap to the innermost open element when it is unrepresented
      if (depth > 0 && ev.edge_position > last_pos && !open_rep[depth-1]) begin
         if (pend_valid && pend_end == last_pos) begin
            pend_end = ev.edge_position;
         end else begin
            if (pend_valid) begin
               word = '{pend_begin, pend_end, 1'b0, 1'b0, 1'b0};
               expected_words.insert(expected_words.size(), word);
            end
            pend_begin = last_pos;
            pend_end   = ev.edge_position;
            pend_valid = 1'b1;
         end
      end
      last_pos = ev.edge_position;

      // push on open, drop when full; pop down to the matching element on close
      if (ev.opens) begin
         if (depth < DEPTH) begin
            open_ids[depth] = ev.element_id;
            open_rep[depth] = ev.represented;
            depth++;
         end else begin
            ovf_seen = 1'b1;
         end
      end else begin
         while (depth > 0) begin
            depth--;
            if (open_ids[depth] == ev.element_id) break;
         end
      end

      // flush the pending span or send an end marker
      if (ev.last_event) begin
         if (pend_valid) word = '{pend_begin, pend_end, 1'b0, 1'b1, ovf_seen};
         else word = '{'0, '0, 1'b1, 1'b1, ovf_seen};
         expected_words.insert(expected_words.size(), word);
         clear_list();
      end
   endfunction

   function void check_word(isgs_pkg::rsp_word_type got);
      isgs_pkg::rsp_word_type want;
      if (expected_words.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected response word: begin=%h end=%h no_span=%b final=%b ovf=%b",
                     got.span_begin, got.span_end, got.no_span, got.final_result,
                     got.stack_overflow);
         return;
      end
      want = expected_words[0];
      expected_words.delete(0);
      if (got.span_begin !== want.span_begin || got.span_end !== want.span_end ||
          got.no_span !== want.no_span || got.final_result !== want.final_result ||
          got.stack_overflow !== want.stack_overflow) begin
         failures++;
         if (failures <= 10) begin
            $display("response mismatch: expected begin=%h end=%h no_span=%b final=%b ovf=%b",
                     want.span_begin, want.span_end, want.no_span, want.final_result,
                     want.stack_overflow);
            $display("                   actual   begin=%h end=%h no_span=%b final=%b ovf=%b",
                     got.span_begin, got.span_end, got.no_span, got.final_result,
                     got.stack_overflow);
         end
      end
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned OPEN_DEPTH    = 64;
   localparam int unsigned RANDOM_EVENTS = 1350;
   localparam int unsigned DRAIN_CYCLES  = 200;
   localparam int unsigned CYCLE_LIMIT   = 2000000;
   localparam int unsigned HOLD_AFTER    = 300;
   localparam int unsigned HOLD_CYCLES   = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int unsigned cycle_count = 0;
   int unsigned accepted_events = 0;

   span_sweep_scoreboard sb = new();

   isgs_req_if req_bus ();
   isgs_rsp_if rsp_bus ();

   innermost_span_gap_sweep_core #(
      .STACK_DEPTH(OPEN_DEPTH),
      .ID_WIDTH(16)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // offer one word and hold it until the core takes it
   task automatic send_event(input logic [31:0] pos, input logic [15:0] id,
                             input bit opens, input bit rep, input bit last, input bit no_gaps);
      int unsigned gap;
      span_event_type ev;
      ev = '{pos, id, opens, rep, last};
      gap = no_gaps ? 0 : pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.edge_position <= pos;
      req_bus.element_id    <= id;
      req_bus.opens         <= opens;
      req_bus.represented   <= rep;
      req_bus.last_event    <= last;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_event(ev);
      accepted_events++;
   endtask

   // build an edge list with random nesting, sorted unless broken, and send it
   task automatic run_random_list(input bit deep, input bit broken);
      span_event_type events [$];
      logic [15:0] open_stack [$];
      span_event_type ev;
      logic [31:0] pos;
      int unsigned count;
      int unsigned r;
      int unsigned pick;
      bit no_gaps;
      bit do_open;

      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r < 6) pos = $urandom_range(0, 4096);
      else if (r < 8) pos = $urandom();
      else pos = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      count = deep ? $urandom_range(66, 80) : $urandom_range(1, 24);

      for (int i = 0; i < count; i++) begin
         // advance the position; broken lists may step back
         r = $urandom_range(0, 99);
         if (r < 25) pos = pos;
         else if (r < 85) pos = pos + $urandom_range(1, 16);
         else if (r < 95) pos = pos + $urandom_range(17, 5000);
         else if (broken) pos = pos - $urandom_range(1, 50);
         else pos = pos + $urandom_range(1, 3);
         ev.edge_position = pos;
         ev.represented   = ($urandom_range(0, 9) < 4);
         ev.last_event    = 1'b0;
         if (deep || open_stack.size() == 0) do_open = ($urandom_range(0, 9) != 0);
         else do_open = ($urandom_range(0, 1) == 0);
         if (do_open) begin
            ev.opens      = 1'b1;
            ev.element_id = 16'($urandom_range(0, 65535));
            open_stack.insert(open_stack.size(), ev.element_id);
         end else begin
            ev.opens = 1'b0;
            r = $urandom_range(0, 9);
            if (open_stack.size() == 0 || (broken && r == 0)) begin
               // stray close of an element that is not open
               ev.element_id = 16'($urandom_range(0, 65535));
            end else if (r < 2) begin
               // close a random open element, overrunning any inner ones
               pick = $urandom_range(0, open_stack.size() - 1);
               ev.element_id = open_stack[pick];
               while (open_stack.size() > pick) open_stack.delete(open_stack.size() - 1);
            end else begin
               ev.element_id = open_stack[open_stack.size() - 1];
               open_stack.delete(open_stack.size() - 1);
            end
         end
         events.insert(events.size(), ev);
      end

      // unless broken, close what is still open, innermost first
      if (!broken) begin
         while (open_stack.size() > 0) begin
            pos = pos + $urandom_range(0, 12);
            ev = '{pos, open_stack[open_stack.size() - 1], 1'b0, 1'b0, 1'b0};
            open_stack.delete(open_stack.size() - 1);
            events.insert(events.size(), ev);
         end
      end
      events[events.size()-1].last_event = 1'b1;

      foreach (events[i])
         send_event(events[i].edge_position, events[i].element_id, events[i].opens,
                    events[i].represented, events[i].last_event, no_gaps);
   endtask

   // response side: check each word, then pick ready for the next cycle
   initial begin : drain_responses
      isgs_pkg::rsp_word_type got;
      int unsigned stall_left;
      int unsigned hold_left;
      int unsigned phase_left;
      bit fast_phase;
      bit pressure_done;
      bit next_ready;
      stall_left    = 0;
      hold_left     = 0;
      phase_left    = 0;
      fast_phase    = 1'b0;
      pressure_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.span_begin     = rsp_bus.span_begin;
            got.span_end       = rsp_bus.span_end;
            got.no_span        = rsp_bus.no_span;
            got.final_result   = rsp_bus.final_result;
            got.stack_overflow = rsp_bus.stack_overflow;
            sb.check_word(got);
         end
         if (phase_left == 0) begin
            fast_phase = ($urandom_range(0, 3) == 0);
            phase_left = $urandom_range(50, 300);
         end else begin
            phase_left--;
         end
         // one long hold so the response queue fills and the request side stalls
         if (!pressure_done && accepted_events >= HOLD_AFTER) begin
            hold_left     = HOLD_CYCLES;
            pressure_done = 1'b1;
         end
         if (reset) begin
            next_ready = 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else if (!fast_phase && $urandom_range(0, 99) < 15) begin
            stall_left = pick_gap();
            next_ready = (stall_left == 0);
         end else begin
            next_ready = 1'b1;
         end
         rsp_bus.ready <= next_ready;
      end
   end

   // request side: directed lists first, then random lists
   initial begin : drive_requests
      int unsigned list_idx;
      int unsigned target;
      req_bus.valid         <= 1'b0;
      req_bus.edge_position <= '0;
      req_bus.element_id    <= '0;
      req_bus.opens         <= 1'b0;
      req_bus.represented   <= 1'b0;
      req_bus.last_event    <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // lone stray close on an empty stack: end marker only
      send_event(32'd0, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0);
      // skip a represented child, then emit the old span and flush the new one together
      send_event(32'd10, 16'h00A1, 1'b1, 1'b0, 1'b0, 1'b0);
      send_event(32'd20, 16'h00B2, 1'b1, 1'b1, 1'b0, 1'b0);
      send_event(32'd30, 16'h00B2, 1'b0, 1'b0, 1'b0, 1'b0);
      send_event(32'd40, 16'h00A1, 1'b0, 1'b0, 1'b1, 1'b0);
      // adjacent stretches of two unrepresented elements merge into one span
      send_event(32'd100, 16'h0011, 1'b1, 1'b0, 1'b0, 1'b1);
      send_event(32'd150, 16'h0022, 1'b1, 1'b0, 1'b0, 1'b1);
      send_event(32'd200, 16'h0022, 1'b0, 1'b0, 1'b0, 1'b1);
      send_event(32'd260, 16'h0011, 1'b0, 1'b0, 1'b1, 1'b1);
      // extreme positions and ids, close of an unknown element, position going back
      send_event(32'hFFFF_FF00, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0);
      send_event(32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0);
      send_event(32'hFFFF_FFFF, 16'h5A5A, 1'b0, 1'b0, 1'b0, 1'b0);
      send_event(32'h0000_0010, 16'h1234, 1'b1, 1'b0, 1'b0, 1'b0);
      send_event(32'h0000_0040, 16'h1234, 1'b0, 1'b0, 1'b1, 1'b0);
      // close of an outer element pops the open children too
      send_event(32'd0, 16'h0A0A, 1'b1, 1'b0, 1'b0, 1'b0);
      send_event(32'd5, 16'h0B0B, 1'b1, 1'b0, 1'b0, 1'b0);
      send_event(32'd9, 16'h0C0C, 1'b1, 1'b1, 1'b0, 1'b0);
      send_event(32'd20, 16'h0A0A, 1'b0, 1'b0, 1'b0, 1'b0);
      send_event(32'd30, 16'h0D0D, 1'b1, 1'b0, 1'b0, 1'b0);
      send_event(32'd31, 16'h0D0D, 1'b0, 1'b0, 1'b1, 1'b0);
      // zero-length element, then a list that ends on an opening edge
      send_event(32'd7, 16'h0077, 1'b1, 1'b0, 1'b0, 1'b0);
      send_event(32'd7, 16'h0077, 1'b0, 1'b0, 1'b1, 1'b0);
      send_event(32'd50, 16'h0055, 1'b1, 1'b0, 1'b1, 1'b0);

      // random lists, every so often a deep one that can overflow the stack
      list_idx = 0;
      target   = accepted_events + RANDOM_EVENTS;
      while (accepted_events < target) begin
         run_random_list(list_idx % 15 == 0, $urandom_range(0, 9) < 2);
         list_idx++;
      end
      req_bus.valid <= 1'b0;

      // wait out the outstanding words, then let the core settle
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // stop a hung run
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

endmodule
